>>> sv/lir_pkg.sv
package lir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 19;
    localparam int CHAN_W   = 2;
    localparam int IDX_W    = 2;
    // Output offset from the newest frame; stays below input rate plus output rate.
    localparam int DIST_W   = RATE_W + 2;
    // Product of a sample and a rate, signed.
    localparam int ACC_W    = SAMPLE_W + RATE_W + 1;
    localparam int MAG_W    = ACC_W - 1;
    localparam int CNT_W    = 5;

    localparam int DEF_MAX_UPSAMPLE = 16;

    localparam logic [RATE_W-1:0] RESET_IN_RATE  = RATE_W'(44100);
    localparam logic [RATE_W-1:0] RESET_OUT_RATE = RATE_W'(44100);
    localparam logic [CHAN_W-1:0] RESET_CHANNELS = CHAN_W'(2);
    localparam logic [CHAN_W-1:0] CHANNELS_MONO  = CHAN_W'(1);

    localparam logic [IDX_W-1:0] REG_INPUT_RATE    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_OUTPUT_RATE   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = IDX_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG,
        S_CALC,
        S_SEG_OUT,
        S_TAIL
    } state_t;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_DIV,
        P_DONE
    } phase_t;

endpackage

>>> sv/lir_chan.sv
module lir_chan
    import lir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SAMPLE_W-1:0] s0,
    input  logic signed [SAMPLE_W-1:0] s1,
    input  logic        [RATE_W-1:0]   rem,
    input  logic        [RATE_W-1:0]   rate,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] result
);

    phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [RATE_W-1:0]         a_reg;
    logic [RATE_W-1:0]         b_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [RATE_W-1:0]         part_reg;
    logic [SAMPLE_W-1:0]       quot_reg;
    logic                      neg_reg;
    logic signed [SAMPLE_W-1:0] result_reg;

    logic signed [ACC_W-1:0]   acc_next;
    logic [MAG_W-1:0]          mag;
    logic [RATE_W:0]           trial;
    logic                      fits;
    logic signed [SAMPLE_W:0]  signed_q;

    // Multiply phase: both weights are walked MSB first, one bit per cycle.
    always_comb
    begin
        acc_next = ACC_W'(acc_reg <<< 1);
        if (a_reg[RATE_W-1])
        begin
            acc_next = acc_next + ACC_W'(s0);
        end
        if (b_reg[RATE_W-1])
        begin
            acc_next = acc_next + ACC_W'(s1);
        end
    end

    assign mag   = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
    assign trial = {part_reg, quot_reg[SAMPLE_W-1]};
    assign fits  = (trial >= {1'b0, rate});
    assign signed_q = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    phase_next = P_MUL;
                end
            end
            P_MUL:
            begin
                if (cnt_reg == CNT_W'(RATE_W))
                begin
                    phase_next = P_DIV;
                end
            end
            P_DIV:
            begin
                if (cnt_reg == CNT_W'(SAMPLE_W))
                begin
                    phase_next = P_DONE;
                end
            end
            P_DONE:
            begin
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg != phase_next)
            begin
                cnt_reg <= '0;
            end
            else if (phase_reg == P_MUL || phase_reg == P_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                acc_reg <= '0;
                a_reg   <= rate - rem;
                b_reg   <= rem;
            end
            P_MUL:
            begin
                if (cnt_reg == CNT_W'(RATE_W))
                begin
                    // Split the magnitude: high part seeds the remainder.
                    neg_reg  <= acc_reg[ACC_W-1];
                    part_reg <= RATE_W'(mag >> SAMPLE_W);
                    quot_reg <= mag[SAMPLE_W-1:0];
                end
                else
                begin
                    acc_reg <= acc_next;
                    a_reg   <= a_reg << 1;
                    b_reg   <= b_reg << 1;
                end
            end
            P_DIV:
            begin
                if (cnt_reg == CNT_W'(SAMPLE_W))
                begin
                    result_reg <= signed_q[SAMPLE_W-1:0];
                end
                else
                begin
                    part_reg <= fits ? RATE_W'(trial - {1'b0, rate}) : trial[RATE_W-1:0];
                    quot_reg <= {quot_reg[SAMPLE_W-2:0], fits};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (phase_reg == P_DONE);
    assign result = result_reg;

endmodule

>>> sv/linear_interp_resampler.sv
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_left, in_right, in_last
// out       out_valid / out_ready     out_left, out_right, run_last, stream_last
// cfg       cfg_write (no wait)       cfg_index, cfg_data
//
// One input frame is taken at a time; in_ready is high only while the block is idle.
// Each interpolated output starts the bit-serial units, waits while they multiply, divide
// and signal done, and then loads the output register. Tail copies load the output
// register directly from the current frame.
// A stalled output register holds the block in place; nothing is dropped.
// Reset is asynchronous and active low; it restores the default rates and clears the stream.
module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int MAX_UPSAMPLE_RATIO = DEF_MAX_UPSAMPLE
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_left,
    input  logic signed [SAMPLE_W-1:0] in_right,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       run_last,
    output logic                       stream_last,
    input  logic                       cfg_write,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [RATE_W-1:0]          cfg_data
);

    localparam int MUL_W = $clog2(MAX_UPSAMPLE_RATIO + 1);
    localparam int LIM_W = RATE_W + MUL_W;

    state_t st_reg, st_next;

    // Configuration registers.
    logic [RATE_W-1:0] in_rate_reg;
    logic [RATE_W-1:0] dst_rate_reg;
    logic [CHAN_W-1:0] chan_reg;

    // Rates and frame captured when a transaction is accepted.
    logic [RATE_W-1:0]          ri_reg;
    logic [RATE_W-1:0]          ro_reg;
    logic                       mono_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] cur_l_reg;
    logic signed [SAMPLE_W-1:0] cur_r_reg;

    // Stream state. The next output position is kept relative to the newest
    // frame position, so it never grows with stream length.
    logic signed [SAMPLE_W-1:0] prev_l_reg;
    logic signed [SAMPLE_W-1:0] prev_r_reg;
    logic                       seen_reg;
    logic [DIST_W-1:0]          d_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg;
    logic signed [SAMPLE_W-1:0] out_r_reg;
    logic                       run_last_reg;
    logic                       stream_last_reg;

    logic [RATE_W-1:0] ri_eff;
    logic [RATE_W-1:0] ro_raw;
    logic [LIM_W-1:0]  ro_limit;
    logic [RATE_W-1:0] ro_eff;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [DIST_W-1:0] d_plus;
    logic              in_window;
    logic              more_seg;
    logic              tail_after;
    logic              seg_run_last;
    logic              unit_start;
    logic              done_l;
    logic              done_r;
    logic signed [SAMPLE_W-1:0] res_l;
    logic signed [SAMPLE_W-1:0] res_r;

    // A zero rate acts as one; the output rate is capped at the upsample limit.
    assign ri_eff   = (in_rate_reg == '0) ? RATE_W'(1) : in_rate_reg;
    assign ro_raw   = (dst_rate_reg == '0) ? RATE_W'(1) : dst_rate_reg;
    assign ro_limit = LIM_W'(ri_eff) * LIM_W'(MAX_UPSAMPLE_RATIO);
    assign ro_eff   = (LIM_W'(ro_raw) > ro_limit) ? ro_limit[RATE_W-1:0] : ro_raw;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    // The output register takes a new transaction in these two places only.
    assign out_load  = ((st_reg == S_SEG_OUT) && out_free)
                    || ((st_reg == S_TAIL) && in_window && out_free);
    assign d_plus    = d_reg + DIST_W'(ri_reg);
    assign in_window = (d_reg < DIST_W'(ro_reg));
    assign more_seg  = (d_plus < DIST_W'(ro_reg));
    // After the segment, the tail emits something only when the next output
    // still lies within one output period past the last frame.
    assign tail_after   = last_reg && ((d_plus - DIST_W'(ro_reg)) < DIST_W'(ro_reg));
    assign seg_run_last = !more_seg && !tail_after;

    assign in_ready   = (st_reg == S_IDLE);
    assign unit_start = (st_reg == S_SEG) && in_window;

    lir_chan u_chan_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .s0     (prev_l_reg),
        .s1     (cur_l_reg),
        .rem    (d_reg[RATE_W-1:0]),
        .rate   (ro_reg),
        .done   (done_l),
        .result (res_l)
    );

    lir_chan u_chan_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .s0     (prev_r_reg),
        .s1     (cur_r_reg),
        .rem    (d_reg[RATE_W-1:0]),
        .rate   (ro_reg),
        .done   (done_r),
        .result (res_r)
    );

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (seen_reg)
                    begin
                        st_next = S_SEG;
                    end
                    else if (in_last)
                    begin
                        st_next = S_TAIL;
                    end
                end
            end
            S_SEG:
            begin
                if (in_window)
                begin
                    st_next = S_CALC;
                end
                else
                begin
                    st_next = last_reg ? S_TAIL : S_IDLE;
                end
            end
            S_CALC:
            begin
                if (done_l)
                begin
                    st_next = S_SEG_OUT;
                end
            end
            S_SEG_OUT:
            begin
                if (out_free)
                begin
                    st_next = S_SEG;
                end
            end
            S_TAIL:
            begin
                if (!in_window)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= S_IDLE;
            in_rate_reg     <= RESET_IN_RATE;
            dst_rate_reg    <= RESET_OUT_RATE;
            chan_reg        <= RESET_CHANNELS;
            seen_reg        <= 1'b0;
            d_reg           <= '0;
            prev_l_reg      <= '0;
            prev_r_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INPUT_RATE:    in_rate_reg  <= cfg_data;
                    REG_OUTPUT_RATE:   dst_rate_reg <= cfg_data;
                    REG_CHANNEL_COUNT: chan_reg     <= cfg_data[CHAN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (st_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        seen_reg <= 1'b1;
                        // The first frame of a stream also becomes the previous frame.
                        if (!seen_reg)
                        begin
                            prev_l_reg <= in_left;
                            prev_r_reg <= (chan_reg == CHANNELS_MONO) ? '0 : in_right;
                        end
                    end
                end
                S_SEG:
                begin
                    if (!in_window)
                    begin
                        d_reg      <= d_reg - DIST_W'(ro_reg);
                        prev_l_reg <= cur_l_reg;
                        prev_r_reg <= cur_r_reg;
                    end
                end
                S_SEG_OUT:
                begin
                    if (out_free)
                    begin
                        d_reg <= d_plus;
                    end
                end
                S_TAIL:
                begin
                    if (in_window)
                    begin
                        if (out_free)
                        begin
                            d_reg <= d_plus;
                        end
                    end
                    else
                    begin
                        // End of stream: start the next one from scratch.
                        seen_reg   <= 1'b0;
                        d_reg      <= '0;
                        prev_l_reg <= '0;
                        prev_r_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ri_reg    <= ri_eff;
            ro_reg    <= ro_eff;
            mono_reg  <= (chan_reg == CHANNELS_MONO);
            last_reg  <= in_last;
            cur_l_reg <= in_left;
            cur_r_reg <= (chan_reg == CHANNELS_MONO) ? '0 : in_right;
        end

        if (st_reg == S_SEG_OUT && out_free)
        begin
            out_l_reg       <= res_l;
            out_r_reg       <= mono_reg ? '0 : res_r;
            run_last_reg    <= seg_run_last;
            stream_last_reg <= seg_run_last && last_reg;
        end
        else if (st_reg == S_TAIL && in_window && out_free)
        begin
            out_l_reg       <= cur_l_reg;
            out_r_reg       <= cur_r_reg;
            run_last_reg    <= !more_seg;
            stream_last_reg <= !more_seg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_left    = out_l_reg;
    assign out_right   = out_r_reg;
    assign run_last    = run_last_reg;
    assign stream_last = stream_last_reg;

    // Both channel units run in lockstep.
    a_units_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_l == done_r)
        else $error("channel units out of step");

    a_calc_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_SEG_OUT) |-> (d_reg < DIST_W'(ro_reg)))
        else $error("interpolation remainder outside the output period");

    a_tail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_TAIL && !in_window) |=> (!seen_reg && d_reg == '0))
        else $error("stream state not cleared after the tail");

    a_stream_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stream_last_reg) |-> run_last_reg)
        else $error("stream end without run end");

endmodule
